### rtl/core/bict_pkg.sv
// Package for the booking interval conflict table.
// Holds the table geometry, the entry layout, status codes and sequencer states.
// No dependencies.
package bict_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W = 6;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int DATE_W = 16;
  localparam int RES_W = 8;
  localparam int MIN_W = 11;

  localparam int LAST_HOUR = 23;
  localparam int LAST_MIN = 59;
  localparam int MINS_PER_HOUR = 60;
  localparam int MAX_MINUTE = LAST_HOUR * MINS_PER_HOUR + LAST_MIN;

  localparam logic KIND_CONFLICT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN    = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef struct packed {
    logic [DATE_W-1:0] date;
    logic [RES_W-1:0]  resource;
    logic [MIN_W-1:0]  start;
    logic [MIN_W-1:0]  stop;
  } booking_t;

  localparam int ENTRY_W = $bits(booking_t);

  typedef struct packed {
    booking_t entry;
    booking_t request;
  } match_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_WRITE,
    S_FINAL
  } state_t;

endpackage

### rtl/core/bict_req_if.sv
// Request channel interface: one booking request per word.
// Depends on bict_pkg for field widths.
interface bict_req_if
  import bict_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATE_W-1:0] date_key;
  logic [RES_W-1:0]  resource_key;
  logic [MIN_W-1:0]  start_minute;
  logic [MIN_W-1:0]  end_minute;

  modport source (output valid, date_key, resource_key, start_minute, end_minute,
                  input ready);
  modport sink (input valid, date_key, resource_key, start_minute, end_minute,
                output ready);
endinterface

### rtl/core/bict_res_if.sv
// Result channel interface: conflict reports and final status words.
// Depends on bict_pkg for field widths.
interface bict_res_if
  import bict_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [5:0]       conflict_index;
  logic [MIN_W-1:0] conflict_start;
  logic [MIN_W-1:0] conflict_end;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, result_kind, conflict_index, conflict_start,
                  conflict_end, status, last, input ready);
  modport sink (input valid, result_kind, conflict_index, conflict_start,
                conflict_end, status, last, output ready);
endinterface

### rtl/core/bict_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bict_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/bict_match.sv
// Shared overlap comparator used once per scanned table entry.
// Depends on bict_pkg for the entry layout.
module bict_match
  import bict_pkg::*;
(
  input  match_req_t req,
  output logic       hit
);

  // Same date and resource, and the half-open intervals overlap.
  assign hit = (req.entry.date == req.request.date)
            && (req.entry.resource == req.request.resource)
            && (req.entry.start < req.request.stop)
            && (req.request.start < req.entry.stop);

endmodule

### rtl/core/bict_ctrl.sv
// Sequencer for the conflict table: request checks, table scan, append and
// the result register. Depends on bict_pkg and both channel interfaces.
module bict_ctrl
  import bict_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  bict_req_if.sink            req,
  bict_res_if.source          res,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [ENTRY_W-1:0]  rd_data,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [ENTRY_W-1:0]  wr_data,
  output match_req_t          match_req,
  input  logic                match_hit
);

  state_t           state;
  state_t           state_next;
  booking_t         request;
  booking_t         entry;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  status_t          fin_status;

  logic out_free;
  logic full;
  logic bad_time;
  logic last_idx;
  logic load_conf;
  logic load_fin;
  logic step;

  assign entry     = booking_t'(rd_data);
  assign out_free  = !res.valid || res.ready;
  assign full      = count >= CNT_W'(TABLE_DEPTH);
  assign bad_time  = (request.start > MIN_W'(MAX_MINUTE))
                  || (request.stop > MIN_W'(MAX_MINUTE))
                  || (request.start >= request.stop);
  assign last_idx  = CNT_W'(idx + 1'b1) == count;

  assign match_req.entry   = entry;
  assign match_req.request = request;

  assign rd_addr = idx[IDX_W-1:0];
  assign wr_addr = count[IDX_W-1:0];
  assign wr_data = request;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (full || bad_time) state_next = S_FINAL;
        else if (count == '0) state_next = S_WRITE;
        else state_next = S_SCAN_RD;
      end
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (match_hit && !out_free) state_next = S_SCAN_CMP;
        else if (last_idx) state_next = S_WRITE;
        else state_next = S_SCAN_RD;
      end
      S_WRITE: state_next = S_FINAL;
      S_FINAL: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    load_conf = 1'b0;
    load_fin  = 1'b0;
    step      = 1'b0;
    unique case (state)
      S_IDLE:     req.ready = 1'b1;
      S_CHECK:    ;
      S_SCAN_RD:  rd_en = 1'b1;
      S_SCAN_CMP: begin
        load_conf = match_hit && out_free;
        step      = !match_hit || out_free;
      end
      S_WRITE:    wr_en = 1'b1;
      S_FINAL:    load_fin = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) count <= CNT_W'(count + 1'b1);
      if (load_conf || load_fin) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      request.date     <= req.date_key;
      request.resource <= req.resource_key;
      request.start    <= req.start_minute;
      request.stop     <= req.end_minute;
    end

    if (state == S_CHECK) begin
      idx <= '0;
      if (full) fin_status <= ST_FULL;
      else if (bad_time) fin_status <= ST_INVALID;
      else fin_status <= ST_CLEAN;
    end else if (step) begin
      idx <= CNT_W'(idx + 1'b1);
    end
    if (load_conf) fin_status <= ST_CONFLICT;

    if (load_conf) begin
      res.result_kind    <= KIND_CONFLICT;
      res.conflict_index <= 6'(idx);
      res.conflict_start <= entry.start;
      res.conflict_end   <= entry.stop;
      res.status         <= ST_CLEAN;
      res.last           <= 1'b0;
    end else if (load_fin) begin
      res.result_kind    <= KIND_FINAL;
      res.conflict_index <= '0;
      res.conflict_start <= '0;
      res.conflict_end   <= '0;
      res.status         <= fin_status;
      res.last           <= 1'b1;
    end
  end

endmodule

### rtl/core/booking_interval_conflict_table.sv
// Top level of the booking interval conflict table.
// Depends on bict_pkg, bict_req_if, bict_res_if, bict_ram, bict_match, bict_ctrl.
//
//   channel | dir | words per request      | payload
//   --------+-----+------------------------+-----------------------------------
//   req     | in  | 1                      | date, resource, start, end minute
//   res     | out | 1 to TABLE_DEPTH       | kind, index, start, end, status, last
//
// A request is accepted in the idle state and then checked; each stored booking is
// read through the single read port of the table RAM and handed to the shared
// overlap comparator, and the request is then appended and closed with its final
// word. A request turned away as full or with a bad time goes straight from the
// check to the final word, with no scan and no append.
// Reset (rst, synchronous) empties the table by clearing the booking count;
// the RAM itself is not cleared, since only entries below the count are read.
// A stalled result channel holds the scan on the entry that hit until the
// result register frees up; the request channel is ready only between requests.

module booking_interval_conflict_table
  import bict_pkg::*;
(
  input logic        clk,
  input logic        rst,
  bict_req_if.sink   req,
  bict_res_if.source res
);

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  match_req_t         match_req;
  logic               match_hit;

  // The sequencer owns the handshakes, the booking count and the result
  // register. It walks the table one entry at a time.
  bict_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .match_req (match_req),
    .match_hit (match_hit)
  );

  // The booking table is append-only: writes always land at the count.
  bict_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // One comparator serves every scanned entry.
  bict_match u_match (
    .req (match_req),
    .hit (match_hit)
  );

endmodule

### tb/sv/bict_conflict_monitor.sv
// Checker for the booking interval conflict table: watches both channels,
// keeps its own copy of the booking table and compares every result word.
// Depends on bict_pkg, bict_req_if and bict_res_if.
`timescale 1ns / 100ps

module bict_conflict_monitor
  import bict_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bict_req_if  req,
  bict_res_if  res,
  output int   fail_count,
  output int   pending,
  output int   words_checked,
  output int   conflicts_seen,
  output int   rejects_seen
);

  typedef struct {
    logic             kind;
    logic [5:0]       index;
    logic [MIN_W-1:0] span_start;
    logic [MIN_W-1:0] span_end;
    status_t          status;
    logic             last;
  } booking_word_t;

  booking_t      booked[TABLE_DEPTH];
  int            booked_count;
  booking_word_t due_words[$];
  booking_word_t got_word;
  booking_t      request;

  initial begin
    fail_count     = 0;
    pending        = 0;
    words_checked  = 0;
    conflicts_seen = 0;
    rejects_seen   = 0;
    booked_count   = 0;
  end

  function automatic booking_word_t closing_word(input status_t st);
    booking_word_t w;
    w.kind       = KIND_FINAL;
    w.index      = '0;
    w.span_start = '0;
    w.span_end   = '0;
    w.status     = st;
    w.last       = 1'b1;
    return w;
  endfunction

  // Works out every word that one accepted request must produce and books it.
  function automatic void book_request(input booking_t rq);
    booking_word_t w;
    logic          hit;
    int            i;
    hit = 1'b0;
    if (booked_count >= TABLE_DEPTH) begin
      due_words.push_back(closing_word(ST_FULL));
      rejects_seen++;
      return;
    end
    if (rq.start > MAX_MINUTE || rq.stop > MAX_MINUTE || rq.start >= rq.stop) begin
      due_words.push_back(closing_word(ST_INVALID));
      rejects_seen++;
      return;
    end
    for (i = 0; i < booked_count; i++) begin
      if (booked[i].date == rq.date && booked[i].resource == rq.resource &&
          booked[i].start < rq.stop && rq.start < booked[i].stop) begin
        w.kind       = KIND_CONFLICT;
        w.index      = 6'(i);
        w.span_start = booked[i].start;
        w.span_end   = booked[i].stop;
        w.status     = ST_CLEAN;
        w.last       = 1'b0;
        due_words.push_back(w);
        conflicts_seen++;
        hit = 1'b1;
      end
    end
    booked[booked_count] = rq;
    booked_count++;
    due_words.push_back(closing_word(hit ? ST_CONFLICT : ST_CLEAN));
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] result mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      booked_count = 0;
      due_words.delete();
    end else begin
      // A result word always belongs to an earlier request, so check it first.
      if (res.valid && res.ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("word with nothing expected, status", int'(res.status), -1);
        end else begin
          got_word = due_words.pop_front();
          if (res.result_kind !== got_word.kind)
            report_mismatch("result_kind", int'(res.result_kind), int'(got_word.kind));
          if (res.conflict_index !== got_word.index)
            report_mismatch("conflict_index", int'(res.conflict_index), int'(got_word.index));
          if (res.conflict_start !== got_word.span_start)
            report_mismatch("conflict_start", int'(res.conflict_start),
                            int'(got_word.span_start));
          if (res.conflict_end !== got_word.span_end)
            report_mismatch("conflict_end", int'(res.conflict_end), int'(got_word.span_end));
          if (res.status !== got_word.status)
            report_mismatch("status", int'(res.status), int'(got_word.status));
          if (res.last !== got_word.last)
            report_mismatch("last", int'(res.last), int'(got_word.last));
          words_checked++;
        end
      end
      if (req.valid && req.ready) begin
        request.date     = req.date_key;
        request.resource = req.resource_key;
        request.start    = req.start_minute;
        request.stop     = req.end_minute;
        book_request(request);
      end
    end
    pending = due_words.size();
  end

endmodule

### tb/sv/booking_interval_conflict_table_tb.sv
// Top of the booking interval conflict table testbench: clock, reset and
// request stimulus, a randomly stalling result sink, and the verdict.
// Depends on bict_pkg, both channel interfaces, the block and bict_conflict_monitor.
`timescale 1ns / 100ps

module booking_interval_conflict_table_tb
  import bict_pkg::*;
;

  // The slowest legal run stays well under this limit: only TABLE_DEPTH requests
  // can ever be stored, so only those scan and stream long conflict lists.
  localparam int CYCLE_LIMIT = 200000;
  // Settle time after the last expected word: one full scan of the table.
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;
  int   hold_left;
  int   requests_sent;
  int   fail_count;
  int   pending;
  int   words_checked;
  int   conflicts_seen;
  int   rejects_seen;

  bict_req_if req ();
  bict_res_if res ();

  booking_interval_conflict_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  bict_conflict_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .res            (res),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .conflicts_seen (conflicts_seen),
    .rejects_seen   (rejects_seen)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake or a missing word ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words still expected.", cycles, pending);
      $display("** booking_interval_conflict_table: FAILED **");
      $finish;
    end
  end

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one. In steady stretches nobody idles at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result sink takes words in bursts and stalls in between, so stalls
  // land on conflict words, final words and the gaps between requests alike.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (steady || $urandom_range(0, 99) < 65) begin
      res.ready = 1'b1;
      hold_left = steady ? 0 : $urandom_range(0, 7);
    end else begin
      res.ready = 1'b0;
      hold_left = pick_gap();
    end
  end

  // Offers one request word and holds it until the block takes it. Called and
  // left at a falling edge; all inputs change only there.
  task automatic send_booking(input logic [DATE_W-1:0] date, input logic [RES_W-1:0] room,
                              input logic [MIN_W-1:0] t_start,
                              input logic [MIN_W-1:0] t_end);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    req.date_key     = date;
    req.resource_key = room;
    req.start_minute = t_start;
    req.end_minute   = t_end;
    req.valid        = 1'b1;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
    // Garbage on an idle channel must never be taken as a request.
    req.date_key     = DATE_W'($urandom);
    req.resource_key = RES_W'($urandom);
    req.start_minute = MIN_W'($urandom);
    req.end_minute   = MIN_W'($urandom);
    requests_sent++;
  endtask

  task automatic wait_all_results();
    while (pending != 0) @(negedge clk);
  endtask

  // Random requests. Most are well formed and crowd onto a few date and room
  // pairs with wide intervals, so later bookings overlap many earlier ones and
  // produce long conflict lists. The rest are bad times near and far from the
  // limit, and fully random words that flip every bit of every field. Once the
  // table is full, all of them must come back as full, bad times included.
  task automatic send_random(input int count);
    logic [DATE_W-1:0] date;
    logic [RES_W-1:0]  room;
    logic [MIN_W-1:0]  t_start;
    logic [MIN_W-1:0]  t_end;
    int                r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 5))
          0, 1, 2: date = 16'd0;
          3:       date = 16'hFFFF;
          default: date = 16'h1234;
        endcase
        case ($urandom_range(0, 5))
          0, 1, 2: room = 8'd0;
          3:       room = 8'hFF;
          default: room = 8'h5A;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          // Short slot anywhere in the day.
          t_start = MIN_W'($urandom_range(0, MAX_MINUTE - 1));
          t_end   = MIN_W'($urandom_range(int'(t_start) + 1,
                                          (int'(t_start) + 30 > MAX_MINUTE) ?
                                          MAX_MINUTE : int'(t_start) + 30));
        end else begin
          // Wide slot straddling midday: overlaps most others on the same pair.
          t_start = MIN_W'($urandom_range(0, 719));
          t_end   = MIN_W'($urandom_range(720, MAX_MINUTE));
        end
      end else if (r < 85) begin
        date = DATE_W'($urandom);
        room = RES_W'($urandom);
        case ($urandom_range(0, 2))
          0: begin
            t_start = MIN_W'($urandom_range(MAX_MINUTE + 1, 2047));
            t_end   = MIN_W'($urandom_range(0, 2047));
          end
          1: begin
            t_start = MIN_W'($urandom_range(0, MAX_MINUTE));
            t_end   = MIN_W'($urandom_range(MAX_MINUTE + 1, 2047));
          end
          default: begin
            t_end   = MIN_W'($urandom_range(0, MAX_MINUTE));
            t_start = MIN_W'($urandom_range(int'(t_end), MAX_MINUTE));
          end
        endcase
      end else begin
        date    = DATE_W'($urandom);
        room    = RES_W'($urandom);
        t_start = MIN_W'($urandom_range(0, 2047));
        t_end   = MIN_W'($urandom_range(0, 2047));
      end
      send_booking(date, room, t_start, t_end);
    end
  endtask

  initial begin
    cycles           = 0;
    hold_left        = 0;
    requests_sent    = 0;
    steady           = 1'b0;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.date_key     = '0;
    req.resource_key = '0;
    req.start_minute = '0;
    req.end_minute   = '0;
    res.ready        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The whole day on the lowest keys, then slots that touch
    // the day's edges, half-open neighbors that only touch, every flavor of
    // bad time, and same-time bookings that differ only in date or room.
    send_booking(16'd0, 8'd0, 11'd0, 11'd1439);
    send_booking(16'd0, 8'd0, 11'd1438, 11'd1439);
    send_booking(16'hFFFF, 8'hFF, 11'd0, 11'd1);
    send_booking(16'hFFFF, 8'hFF, 11'd1, 11'd2);
    send_booking(16'hFFFF, 8'hFF, 11'd0, 11'd2);
    send_booking(16'd0, 8'd0, 11'd1440, 11'd1500);
    send_booking(16'd0, 8'd0, 11'd0, 11'd1440);
    send_booking(16'd0, 8'd0, 11'd500, 11'd500);
    send_booking(16'd0, 8'd0, 11'd900, 11'd100);
    send_booking(16'hFFFF, 8'hFF, 11'd2047, 11'd2047);
    send_booking(16'hFFFF, 8'hFF, 11'd0, 11'd2047);
    send_booking(16'hFFFF, 8'hFF, 11'd1439, 11'd1439);
    send_booking(16'd0, 8'd1, 11'd0, 11'd1439);
    send_booking(16'd1, 8'd0, 11'd0, 11'd1439);
    send_booking(16'd0, 8'd0, 11'd600, 11'd700);
    send_booking(16'd0, 8'd0, 11'd1000, 11'd1439);
    send_booking(16'd0, 8'd0, 11'd700, 11'd1000);

    // Let the block drain completely before the random part starts.
    wait_all_results();

    send_random(40);
    wait_all_results();

    // A stretch with no idling on either side.
    steady = 1'b1;
    send_random(20);
    steady = 1'b0;

    send_random(23);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d booking requests and checked %0d result words, %0d conflict reports.",
             requests_sent, words_checked, conflicts_seen);
    $display("%0d requests were turned away as full or with a bad time.", rejects_seen);
    if (fail_count == 0) begin
      $display("** booking_interval_conflict_table: PASSED **");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("** booking_interval_conflict_table: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bict_pkg.sv
rtl/core/bict_req_if.sv
rtl/core/bict_res_if.sv
rtl/core/bict_ram.sv
rtl/core/bict_match.sv
rtl/core/bict_ctrl.sv
rtl/core/booking_interval_conflict_table.sv
tb/sv/bict_conflict_monitor.sv
tb/sv/booking_interval_conflict_table_tb.sv
